@@ src/double_ended_queue_core_macros.svh @@
// assertion macros used by the deque datapath
// needs a clock named clock and a reset named reset in the calling module
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque assertion failed");

`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`else

`define DEQ_ASSERT_IMPL(label, ante, cons)

`define DEQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/deq_pkg.sv @@
// shared constants and control types for the double-ended queue
// no dependencies
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LIST_FWD   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LIST_BWD   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic op_valid;    // single-result operation accepted this cycle
      logic list_start;  // non-empty listing accepted this cycle
      logic list_issue;  // read the next listed entry
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic out_free;    // output register can take an item this cycle
      logic rd_busy;     // a listed entry sits in the memory read stage
      logic stage_free;  // the read stage can take a new read this cycle
      logic list_last;   // the next read is the final entry of the listing
   } status_type;

endpackage

@@ src/deq_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/deq_ctrl.sv @@
// deque controller: accepts items, decodes the operation, sequences listings
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [deq_pkg::FUNC_W-1:0]   func,
   input  deq_pkg::status_type          status,
   output deq_pkg::cmd_type             cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && status.out_free && !status.rd_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      cmd.op_valid   = 1'b0;
      cmd.list_start = 1'b0;
      cmd.list_issue = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  deq_pkg::FUNC_PUSH_FRONT,
                  deq_pkg::FUNC_PUSH_BACK,
                  deq_pkg::FUNC_POP_FRONT,
                  deq_pkg::FUNC_POP_BACK: begin
                     cmd.op_valid = 1'b1;
                  end
                  deq_pkg::FUNC_LIST_FWD,
                  deq_pkg::FUNC_LIST_BWD: begin
                     // empty listing answers like a single operation
                     if (status.empty) begin
                        cmd.op_valid = 1'b1;
                     end else begin
                        cmd.list_start = 1'b1;
                        state_in       = ST_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            cmd.list_issue = status.stage_free;
            if (status.stage_free && status.list_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/deq_dp.sv @@
// deque datapath: ring pointers, entry memory, listing read stage, output register
// depends on deq_pkg, deq_ram and the assertion macro header
`timescale 1ns / 1ps
`include "double_ended_queue_core_macros.svh"

module deq_dp #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [deq_pkg::FUNC_W-1:0]    func,
   input  logic [deq_pkg::DATA_W-1:0]    item,
   input  deq_pkg::cmd_type              cmd,
   output deq_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [deq_pkg::DATA_W-1:0]    rsp_value,
   output logic [deq_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          dir_bwd_ff, dir_bwd_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [deq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                       empty, full;
   logic                       out_free, ram_load, stage_free;
   logic [SW-1:0]              back_sum, list_pos, list_sum;
   logic [AW-1:0]              back_slot, list_slot, front_dec;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [deq_pkg::DATA_W-1:0] rd_data;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == DEPTH_C);

   // ring index arithmetic: sums stay below twice the depth
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
   assign list_pos  = dir_bwd_ff ? (SW'(count_ff) - SW'(1) - SW'(idx_ff)) : SW'(idx_ff);
   assign list_sum  = SW'(front_ff) + list_pos;
   assign list_slot = (list_sum >= DEPTH_S) ? AW'(list_sum - DEPTH_S) : AW'(list_sum);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ram_load   = rd_vld_ff && out_free;
   assign stage_free = !rd_vld_ff || ram_load;

   assign status.empty      = empty;
   assign status.out_free   = out_free;
   assign status.rd_busy    = rd_vld_ff;
   assign status.stage_free = stage_free;
   assign status.list_last  = (SW'(idx_ff) == SW'(count_ff) - SW'(1));

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = back_slot;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.op_valid) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         case (func)
            deq_pkg::FUNC_PUSH_FRONT,
            deq_pkg::FUNC_PUSH_BACK: begin
               rsp_value_in = item;
               if (full) begin
                  rsp_status_in = deq_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = deq_pkg::STATUS_OK;
                  wr_en         = 1'b1;
                  count_in      = count_ff + CW'(1);
                  if (func == deq_pkg::FUNC_PUSH_FRONT) begin
                     front_in = front_dec;
                     wr_addr  = front_dec;
                  end
               end
            end
            deq_pkg::FUNC_POP_FRONT,
            deq_pkg::FUNC_POP_BACK: begin
               rsp_value_in = '0;
               if (empty) begin
                  rsp_status_in = deq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_status_in = deq_pkg::STATUS_OK;
                  count_in      = count_ff - CW'(1);
                  if (func == deq_pkg::FUNC_POP_FRONT) begin
                     front_in = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
                  end
               end
            end
            default: begin
               // listing of an empty queue
               rsp_value_in  = '0;
               rsp_status_in = deq_pkg::STATUS_EMPTY;
            end
         endcase
      end else if (ram_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rd_data;
         rsp_status_in = deq_pkg::STATUS_OK;
         rsp_last_in   = rd_last_ff;
      end
   end

   always_comb begin
      idx_in     = idx_ff;
      dir_bwd_in = dir_bwd_ff;
      rd_last_in = rd_last_ff;
      rd_vld_in  = rd_vld_ff && !ram_load;
      if (cmd.list_start) begin
         idx_in     = '0;
         dir_bwd_in = (func == deq_pkg::FUNC_LIST_BWD);
      end else if (cmd.list_issue) begin
         idx_in     = idx_ff + AW'(1);
         rd_vld_in  = 1'b1;
         rd_last_in = status.list_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      dir_bwd_ff    <= dir_bwd_in;
      rd_last_ff    <= rd_last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item),
      .rd_en   (cmd.list_issue),
      .rd_addr (list_slot),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   `DEQ_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= DEPTH_C)
   `DEQ_ASSERT_IMPL(a_no_op_during_read, cmd.op_valid, !rd_vld_ff)
   `DEQ_ASSERT_IMPL(a_issue_nonempty, cmd.list_issue, !empty && stage_free)
   `DEQ_ASSERT_NEXT(a_list_keeps_state, cmd.list_issue, $stable(count_ff) && $stable(front_ff))

endmodule

@@ src/double_ended_queue_core.sv @@
// Bounded double-ended queue of signed 32-bit words in a ring buffer of DEPTH
// entries. Push and pop items, and listings of an empty queue, each give one status item.
// A listing of N entries gives N items: once the listing is taken, each entry is read
// through the memory read stage into the output register, one per cycle while the
// receiver keeps up, and the input stays closed until the last entry has left the
// memory read stage; the single read port of the entry memory sets that pace. A new
// input item is taken only while the output register is empty or its item is being
// taken. No clearing pass after reset: only live entries are ever read.
// depends on deq_pkg, deq_ctrl, deq_dp
`timescale 1ns / 1ps

module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // func [2:0], item [34:3], zero [39:35]
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // value [31:0], status [33:32], zero [39:34]
   output logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int ITEM_LO = deq_pkg::FUNC_W;
   localparam int PAD_W   = deq_pkg::RSP_TDATA_W - deq_pkg::DATA_W - deq_pkg::STATUS_W;

   deq_pkg::cmd_type                cmd;
   deq_pkg::status_type             status;
   logic [deq_pkg::FUNC_W-1:0]      func;
   logic [deq_pkg::DATA_W-1:0]      item;
   logic [deq_pkg::DATA_W-1:0]      rsp_value;
   logic [deq_pkg::STATUS_W-1:0]    rsp_status;

   assign func = req_tdata[deq_pkg::FUNC_W-1:0];
   assign item = req_tdata[ITEM_LO +: deq_pkg::DATA_W];

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .func       (func),
      .status     (status),
      .cmd        (cmd)
   );

   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .func       (func),
      .item       (item),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_status, rsp_value};

endmodule

@@ verif/double_ended_queue_core_test.sv @@
// self-checking testbench for double_ended_queue_core: directed table, a fill past full, then random traffic
// predicts every response item with its own deque model; depends on deq_pkg and the core rtl
`timescale 1ns / 1ps

module double_ended_queue_core_test;

   localparam int DEPTH        = deq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int SETTLE       = 20;
   localparam int N_DIRECTED   = 24;

   // codes the core ignores
   localparam logic [deq_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [deq_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   typedef struct packed {
      logic [deq_pkg::DATA_W-1:0]   value;
      logic [deq_pkg::STATUS_W-1:0] status;
      logic                         last;
   } rsp_item_type;

   typedef struct packed {
      logic [deq_pkg::FUNC_W-1:0]   func;
      logic [deq_pkg::DATA_W-1:0]   item;
      logic                         typed;
      logic [deq_pkg::DATA_W-1:0]   value;
      logic [deq_pkg::STATUS_W-1:0] status;
   } stim_row_type;

   // typed rows carry a single response with last set
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY},
      '{deq_pkg::FUNC_POP_BACK,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY},
      '{deq_pkg::FUNC_LIST_FWD,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY},
      '{deq_pkg::FUNC_LIST_BWD,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY},
      '{FUNC_SPARE_A,             32'h1234_5678, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h8000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_LIST_FWD,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_LIST_BWD,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{FUNC_SPARE_B,             32'hFFFF_FFFF, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_LIST_FWD,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_FRONT, 32'h5555_5555, 1'b1, 32'h5555_5555, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_PUSH_BACK,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_LIST_BWD,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_OK},
      '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY},
      '{deq_pkg::FUNC_LIST_FWD,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STATUS_EMPTY}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // func [2:0], item [34:3], zero [39:35]
   logic [deq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // value [31:0], status [33:32], zero [39:34]
   logic [deq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;

   double_ended_queue_core #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // predicted deque contents
   logic [deq_pkg::DATA_W-1:0] slot_mem [DEPTH];
   int unsigned                head_slot = 0;
   int unsigned                live_count = 0;
   rsp_item_type               rsp_due [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_req = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   bit  filling = 1'b1;
   int  edge_hits = 0;

   function automatic void due_rsp(input logic [deq_pkg::DATA_W-1:0] v,
                                   input logic [deq_pkg::STATUS_W-1:0] s,
                                   input logic l);
      rsp_item_type r;
      r.value = v;
      r.status = s;
      r.last = l;
      rsp_due.push_back(r);
   endfunction

   function automatic void predict_rsp(input logic [deq_pkg::FUNC_W-1:0] f,
                                       input logic [deq_pkg::DATA_W-1:0] v);
      int unsigned slot;
      int unsigned pos;
      case (f)
         deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
            if (live_count >= DEPTH) begin
               due_rsp(v, deq_pkg::STATUS_FULL, 1'b1);
            end else begin
               if (f == deq_pkg::FUNC_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  slot = head_slot;
               end else begin
                  slot = (head_slot + live_count) % DEPTH;
               end
               slot_mem[slot] = v;
               live_count++;
               due_rsp(v, deq_pkg::STATUS_OK, 1'b1);
            end
         end
         deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
            if (live_count == 0) begin
               due_rsp('0, deq_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               if (f == deq_pkg::FUNC_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
               live_count--;
               due_rsp('0, deq_pkg::STATUS_OK, 1'b1);
            end
         end
         deq_pkg::FUNC_LIST_FWD, deq_pkg::FUNC_LIST_BWD: begin
            if (live_count == 0) begin
               due_rsp('0, deq_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               for (int unsigned i = 0; i < live_count; i++) begin
                  pos = (f == deq_pkg::FUNC_LIST_FWD) ? i : live_count - 1 - i;
                  due_rsp(slot_mem[(head_slot + pos) % DEPTH], deq_pkg::STATUS_OK,
                          i + 1 == live_count);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // offer one item, predict its responses once it is taken
   task automatic send_item(input logic [deq_pkg::FUNC_W-1:0] f,
                            input logic [deq_pkg::DATA_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {5'b0, v, f};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rsp(f, v);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [deq_pkg::DATA_W-1:0] pick_item();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // fill toward full, linger there, then drain toward empty, and so on
   task automatic run_random(input int n_items);
      int taken;
      int r;
      logic [deq_pkg::FUNC_W-1:0] f;
      taken = 0;
      while (taken < n_items) begin
         r = $urandom_range(99);
         if (filling) begin
            if (r < 80)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
            else if (r < 85)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
            else if (r < 95)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_LIST_BWD : deq_pkg::FUNC_LIST_FWD;
            else
               f = ($urandom_range(1) != 0) ? FUNC_SPARE_B : FUNC_SPARE_A;
         end else begin
            if (r < 70)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
            else if (r < 85)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
            else if (r < 95)
               f = ($urandom_range(1) != 0) ? deq_pkg::FUNC_LIST_BWD : deq_pkg::FUNC_LIST_FWD;
            else
               f = ($urandom_range(1) != 0) ? FUNC_SPARE_B : FUNC_SPARE_A;
         end
         send_item(f, pick_item());
         if (f != FUNC_SPARE_A && f != FUNC_SPARE_B) taken++;
         if ((filling && live_count == DEPTH) || (!filling && live_count == 0)) begin
            edge_hits++;
            if (edge_hits >= 3) begin
               filling = !filling;
               edge_hits = 0;
            end
         end
      end
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected item value %h status %0d last %b", $time,
                     rsp_tdata[31:0], rsp_tdata[33:32], rsp_tlast);
            error_count++;
         end else begin
            want = rsp_due.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $display("%0t: value expected %h actual %h", $time, want.value, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[33:32] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tdata[33:32]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 70;
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(DIRECTED[i].func, DIRECTED[i].item);
         if (DIRECTED[i].typed) begin
            void'(rsp_due.pop_back());
            due_rsp(DIRECTED[i].value, DIRECTED[i].status, 1'b1);
         end
      end
      wait_drained();

      // output held off at the start; pushes then run past full, followed by a full listing
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      for (int i = 0; i < DEPTH + 3; i++) begin
         send_item(($urandom_range(1) != 0) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT,
                   pick_item());
      end
      send_item(deq_pkg::FUNC_LIST_FWD, '0);
      wait_drained();
      filling = 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 70;
      run_random(30);
      wait_drained();
      send_idle_pct = 70;
      recv_idle_pct = 15;
      run_random(30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(30);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue_core.sv
verif/double_ended_queue_core_test.sv
